// File: hdl/jitter_buffer_sorted_playout_defines.svh
`ifndef JITTER_BUFFER_SORTED_PLAYOUT_DEFINES_SVH
`define JITTER_BUFFER_SORTED_PLAYOUT_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define JBSP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define JBSP_ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

// File: hdl/jbsp_pkg.sv
package jbsp_pkg;

   localparam int DEF_CAPACITY = 64;
   localparam int DEF_SEQ_BITS = 16;

   localparam int TIME_W    = 48;
   localparam int FLAGS_W   = 8;
   localparam int PAYLOAD_W = 32;
   localparam int COUNT_W   = 7;
   localparam int HSEQ_W    = 16;

   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_POP   = 2'd1,
      OP_FLUSH = 2'd2,
      OP_PEEK  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_NOT_DUE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_CMP,
      S_INS,
      S_POP,
      S_DONE
   } state_type;

   typedef struct packed {
      logic compare;
      logic insert;
      logic shift_left;
   } ctl_type;

endpackage

// File: hdl/jbsp_cell.sv
module jbsp_cell #(
   parameter int SEQ_BITS = jbsp_pkg::DEF_SEQ_BITS,
   parameter int ENT_W    = SEQ_BITS + jbsp_pkg::TIME_W + jbsp_pkg::FLAGS_W
                            + jbsp_pkg::PAYLOAD_W
) (
   input  logic              clock,
   input  logic              reset,
   input  jbsp_pkg::ctl_type ctl,
   input  logic              occupied,
   input  logic              at_tail,
   input  logic [ENT_W-1:0]  new_ent,
   input  logic [ENT_W-1:0]  left_ent,
   input  logic [ENT_W-1:0]  right_ent,
   input  logic              found_in,
   output logic              found_out,
   output logic [ENT_W-1:0]  ent
);

   logic [ENT_W-1:0]    ent_ff, ent_in;
   logic                before_ff, before_in;
   logic [SEQ_BITS-1:0] seq_diff;

   assign seq_diff  = new_ent[SEQ_BITS-1:0] - ent_ff[SEQ_BITS-1:0];
   assign before_in = ctl.compare ? (occupied & seq_diff[SEQ_BITS-1]) : before_ff;
   assign found_out = found_in | before_ff;
   assign ent       = ent_ff;

   always_comb begin
      ent_in = ent_ff;
      if (ctl.shift_left) begin
         ent_in = right_ent;
      end else if (ctl.insert) begin
         if (found_in) begin
            ent_in = left_ent;
         end else if (before_ff || at_tail) begin
            ent_in = new_ent;
         end
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
      if (reset) begin
         before_ff <= 1'b0;
      end else begin
         before_ff <= before_in;
      end
   end

endmodule

// File: hdl/jitter_buffer_sorted_playout.sv
// A push runs EXEC, CMP, INS, DONE; a pop EXEC, POP, DONE (EXEC, DONE when empty); flush
// and peek EXEC, DONE. A new transaction is taken only in IDLE, once DONE has passed on
// the last result. A push into a full buffer drops the head in its first step at no extra
// cost. Push time is set by the compare and insert steps over the cell row and found chain.
// Synchronous active-high reset empties the buffer, clears the delay register
// and drops any pending result; entry contents are not cleared.
`include "jitter_buffer_sorted_playout_defines.svh"

module jitter_buffer_sorted_playout #(
   parameter int CAPACITY = jbsp_pkg::DEF_CAPACITY,
   parameter int SEQ_BITS = jbsp_pkg::DEF_SEQ_BITS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // op[1:0], seq_num[17:2], capture_time[65:18], pkt_flags[73:66],
   // payload_tag[105:74], now_time[153:106], zero[159:154]
   input  logic [159:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[1:0], count[8:2], head_seq[24:9], head_capture[72:25],
   // head_flags[80:73], head_payload[112:81], late[113], zero[119:114]
   output logic [119:0] rsp_tdata,
   input  logic         csr_wen,
   input  logic [47:0]  csr_wdata
);

   localparam int TW    = jbsp_pkg::TIME_W;
   localparam int FW    = jbsp_pkg::FLAGS_W;
   localparam int PW    = jbsp_pkg::PAYLOAD_W;
   localparam int ENT_W = SEQ_BITS + TW + FW + PW;
   localparam int OCC_W = $clog2(CAPACITY + 1);
   localparam int CAP_LO = SEQ_BITS;
   localparam int FLG_LO = SEQ_BITS + TW;
   localparam int PAY_LO = SEQ_BITS + TW + FW;

   jbsp_pkg::state_type  state_ff, state_in;
   jbsp_pkg::op_type     op_ff, op_in;
   jbsp_pkg::status_type status_ff, status_in;
   jbsp_pkg::ctl_type    ctl;

   logic [SEQ_BITS-1:0] seq_ff, seq_in;
   logic [TW-1:0]       cap_ff, cap_in;
   logic [FW-1:0]       flags_ff, flags_in;
   logic [PW-1:0]       pay_ff, pay_in;
   logic [TW-1:0]       now_ff, now_in;
   logic [TW-1:0]       delay_ff, delay_in;
   logic [OCC_W-1:0]    occ_ff, occ_in;
   logic [TW:0]         due_ff, due_in;
   logic                popped_ff, popped_in;
   logic                late_ff, late_in;
   logic [ENT_W-1:0]    pop_ent_ff, pop_ent_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [119:0]        rsp_data_ff, rsp_data_in;

   logic                req_accept;
   logic                load_rsp;
   logic [ENT_W-1:0]    new_ent;
   logic [ENT_W-1:0]    cell_ent [CAPACITY];
   logic [CAPACITY:0]   found;
   logic [ENT_W-1:0]    head_ent;
   logic                has_head;
   logic [TW+1:0]       late_limit;

   assign req_tready = (state_ff == jbsp_pkg::S_IDLE);
   assign req_accept = req_tvalid & req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign new_ent    = {pay_ff, flags_ff, cap_ff, seq_ff};
   assign found[0]   = 1'b0;
   assign late_limit = {1'b0, due_ff} + {2'b00, delay_ff};

   genvar i;
   generate
      for (i = 0; i < CAPACITY; i++) begin : g_cell
         logic [ENT_W-1:0] left_ent, right_ent;
         if (i == 0) begin : g_first
            assign left_ent = new_ent;
         end else begin : g_mid
            assign left_ent = cell_ent[i-1];
         end
         if (i == CAPACITY - 1) begin : g_last
            assign right_ent = cell_ent[i];
         end else begin : g_inner
            assign right_ent = cell_ent[i+1];
         end
         jbsp_cell #(
            .SEQ_BITS(SEQ_BITS),
            .ENT_W   (ENT_W)
         ) u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctl      (ctl),
            .occupied (occ_ff > OCC_W'(i)),
            .at_tail  (occ_ff == OCC_W'(i)),
            .new_ent  (new_ent),
            .left_ent (left_ent),
            .right_ent(right_ent),
            .found_in (found[i]),
            .found_out(found[i+1]),
            .ent      (cell_ent[i])
         );
      end
   endgenerate

   always_comb begin
      seq_in   = seq_ff;
      cap_in   = cap_ff;
      flags_in = flags_ff;
      pay_in   = pay_ff;
      now_in   = now_ff;
      op_in    = op_ff;
      if (req_accept) begin
         op_in    = jbsp_pkg::op_type'(req_tdata[1:0]);
         seq_in   = SEQ_BITS'(req_tdata[17:2]);
         cap_in   = req_tdata[65:18];
         flags_in = req_tdata[73:66];
         pay_in   = req_tdata[105:74];
         now_in   = req_tdata[153:106];
      end
      delay_in = csr_wen ? csr_wdata : delay_ff;
   end

   always_comb begin
      state_in   = state_ff;
      occ_in     = occ_ff;
      status_in  = status_ff;
      popped_in  = popped_ff;
      late_in    = late_ff;
      pop_ent_in = pop_ent_ff;
      due_in     = due_ff;
      ctl        = '0;
      load_rsp   = 1'b0;
      case (state_ff)
         jbsp_pkg::S_IDLE: begin
            if (req_accept) begin
               status_in = jbsp_pkg::ST_OK;
               popped_in = 1'b0;
               late_in   = 1'b0;
               state_in  = jbsp_pkg::S_EXEC;
            end
         end
         jbsp_pkg::S_EXEC: begin
            case (op_ff)
               jbsp_pkg::OP_PUSH: begin
                  if (occ_ff == OCC_W'(CAPACITY)) begin
                     ctl.shift_left = 1'b1;
                     occ_in         = occ_ff - 1'b1;
                  end
                  state_in = jbsp_pkg::S_CMP;
               end
               jbsp_pkg::OP_POP: begin
                  if (occ_ff == '0) begin
                     status_in = jbsp_pkg::ST_EMPTY;
                     state_in  = jbsp_pkg::S_DONE;
                  end else begin
                     due_in   = {1'b0, cell_ent[0][FLG_LO-1:CAP_LO]} + {1'b0, delay_ff};
                     state_in = jbsp_pkg::S_POP;
                  end
               end
               jbsp_pkg::OP_FLUSH: begin
                  occ_in   = '0;
                  state_in = jbsp_pkg::S_DONE;
               end
               default: begin
                  status_in = (occ_ff != '0) ? jbsp_pkg::ST_OK : jbsp_pkg::ST_EMPTY;
                  state_in  = jbsp_pkg::S_DONE;
               end
            endcase
         end
         jbsp_pkg::S_CMP: begin
            ctl.compare = 1'b1;
            state_in    = jbsp_pkg::S_INS;
         end
         jbsp_pkg::S_INS: begin
            ctl.insert = 1'b1;
            occ_in     = occ_ff + 1'b1;
            state_in   = jbsp_pkg::S_DONE;
         end
         jbsp_pkg::S_POP: begin
            if ({1'b0, now_ff} >= due_ff) begin
               popped_in      = 1'b1;
               pop_ent_in     = cell_ent[0];
               late_in        = ({2'b00, now_ff} > late_limit);
               ctl.shift_left = 1'b1;
               occ_in         = occ_ff - 1'b1;
            end else begin
               status_in = jbsp_pkg::ST_NOT_DUE;
            end
            state_in = jbsp_pkg::S_DONE;
         end
         jbsp_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               load_rsp = 1'b1;
               state_in = jbsp_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = jbsp_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      head_ent     = popped_ff ? pop_ent_ff : cell_ent[0];
      has_head     = popped_ff | (occ_ff != '0);
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      if (load_rsp) begin
         rsp_valid_in        = 1'b1;
         rsp_data_in         = '0;
         rsp_data_in[1:0]    = status_ff;
         rsp_data_in[8:2]    = jbsp_pkg::COUNT_W'(occ_ff);
         rsp_data_in[113]    = late_ff;
         if (has_head) begin
            rsp_data_in[24:9]   = jbsp_pkg::HSEQ_W'(head_ent[SEQ_BITS-1:0]);
            rsp_data_in[72:25]  = head_ent[FLG_LO-1:CAP_LO];
            rsp_data_in[80:73]  = head_ent[PAY_LO-1:FLG_LO];
            rsp_data_in[112:81] = head_ent[ENT_W-1:PAY_LO];
         end
      end
   end

   always_ff @(posedge clock) begin
      seq_ff      <= seq_in;
      cap_ff      <= cap_in;
      flags_ff    <= flags_in;
      pay_ff      <= pay_in;
      now_ff      <= now_in;
      op_ff       <= op_in;
      due_ff      <= due_in;
      pop_ent_ff  <= pop_ent_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= jbsp_pkg::S_IDLE;
         occ_ff       <= '0;
         delay_ff     <= '0;
         status_ff    <= jbsp_pkg::ST_OK;
         popped_ff    <= 1'b0;
         late_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         delay_ff     <= delay_in;
         status_ff    <= status_in;
         popped_ff    <= popped_in;
         late_ff      <= late_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `JBSP_ASSERT_NEVER(a_occ_bound, occ_ff > OCC_W'(CAPACITY), "occupancy above capacity")
   `JBSP_ASSERT(a_ins_grows,
      state_ff == jbsp_pkg::S_INS |=> occ_ff == $past(occ_ff) + 1'b1,
      "insert did not add an entry")
   `JBSP_ASSERT(a_flush_empty,
      state_ff == jbsp_pkg::S_EXEC && op_ff == jbsp_pkg::OP_FLUSH |=> occ_ff == '0,
      "flush left entries")
   `JBSP_ASSERT_NEVER(a_late_needs_pop, late_ff && !popped_ff, "late mark without a pop")

endmodule
